FILE: src/cbti_pkg.sv
package cbti_pkg;

  localparam int CFG_W           = 64;
  localparam int CNT_W           = 5;
  localparam int SYM_SLOTS       = 16;
  localparam int VALUE_W         = 32;
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int REG_IDX_W       = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Alphabet as seen by the parser
  typedef struct packed {
    logic [SYM_SLOTS-1:0][7:0] symbols;
    logic [CNT_W-1:0]          base;
    logic                      valid;
  } alpha_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

FILE: src/cbti_if.sv
interface cbti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_string;

  modport source (output valid, output ch, output end_of_string, input ready);
  modport sink (input valid, input ch, input end_of_string, output ready);
endinterface

interface cbti_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbti_pkg::VALUE_W-1:0] value;
  logic                                alphabet_valid;

  modport source (output valid, output value, output alphabet_valid, input ready);
  modport sink (input valid, input value, input alphabet_valid, output ready);
endinterface

FILE: src/cbti_alpha.sv
module cbti_alpha #(
  parameter int MaxSymbols = cbti_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cbti_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [cbti_pkg::CFG_W-1:0]           cfg_wdata,
  output cbti_pkg::alpha_t                     alpha
);

  logic [cbti_pkg::CFG_W-1:0] symbols_low;
  logic [cbti_pkg::CFG_W-1:0] symbols_high;
  logic [cbti_pkg::CNT_W-1:0] symbol_count;

  localparam logic [cbti_pkg::CNT_W-1:0] MaxCnt = cbti_pkg::CNT_W'(MaxSymbols);
  localparam logic [cbti_pkg::CNT_W-1:0] MinCnt = cbti_pkg::CNT_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
      symbol_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbti_pkg::REG_SYMBOLS_LOW:  symbols_low  <= cfg_wdata;
        cbti_pkg::REG_SYMBOLS_HIGH: symbols_high <= cfg_wdata;
        cbti_pkg::REG_SYMBOL_COUNT: symbol_count <= cfg_wdata[cbti_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [cbti_pkg::SYM_SLOTS-1:0][7:0] syms;
  logic                                ok;

  assign syms = {symbols_high, symbols_low};

  // Count range check, then reserved-character and pairwise checks over the symbols in use
  always_comb begin
    ok = (symbol_count >= MinCnt) && (symbol_count <= MaxCnt);
    for (int i = 0; i < MaxSymbols; i++) begin
      if (cbti_pkg::CNT_W'(i) < symbol_count) begin
        if (syms[i] == cbti_pkg::CH_NUL || cbti_pkg::is_space(syms[i]) ||
            syms[i] == cbti_pkg::CH_PLUS || syms[i] == cbti_pkg::CH_MINUS) begin
          ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (syms[j] == syms[i]) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

  assign alpha.symbols = syms;
  assign alpha.base    = (symbol_count > MaxCnt) ? MaxCnt : symbol_count;
  assign alpha.valid   = ok;

endmodule

FILE: src/cbti_parse.sv
module cbti_parse #(
  parameter int MaxSymbols = cbti_pkg::MAX_SYMBOLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cbti_pkg::alpha_t  alpha,
  cbti_in_if.sink           text,
  cbti_out_if.source        result
);

  localparam int IdxW = (MaxSymbols > 1) ? $clog2(MaxSymbols) : 1;

  typedef enum logic [1:0] {PH_SPACE, PH_SIGN, PH_DIGIT, PH_STOP} phase_t;

  // Input register
  logic       in_vld;
  logic [7:0] in_ch;
  logic       in_eos;

  // Parse state and result register
  phase_t                              phase;
  logic                                negative;
  logic [cbti_pkg::VALUE_W-1:0]        accum;
  logic                                out_vld;
  logic signed [cbti_pkg::VALUE_W-1:0] out_value;
  logic                                out_ok;

  phase_t                              phase_next;
  logic                                negative_next;
  logic [cbti_pkg::VALUE_W-1:0]        accum_next;
  logic [cbti_pkg::VALUE_W-1:0]        acc_mul;
  logic signed [cbti_pkg::VALUE_W-1:0] value_next;
  logic                                hit;
  logic [IdxW-1:0]                     pos;
  logic                                advance;

  // A held request moves on unless it makes a result that cannot be placed
  assign advance    = in_vld && (!in_eos || !out_vld || result.ready);
  assign text.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (text.ready) begin
      in_vld <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      in_ch  <= text.ch;
      in_eos <= text.end_of_string;
    end
  end

  // Lowest matching position wins
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = MaxSymbols - 1; i >= 0; i--) begin
      if ((cbti_pkg::CNT_W'(i) < alpha.base) && (alpha.symbols[i] == in_ch)) begin
        hit = 1'b1;
        pos = IdxW'(i);
      end
    end
  end

  assign acc_mul = cbti_pkg::VALUE_W'(accum * cbti_pkg::VALUE_W'(alpha.base));

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    accum_next    = accum;
    if (phase_next == PH_SPACE && !cbti_pkg::is_space(in_ch)) begin
      phase_next = PH_SIGN;
    end
    if (phase_next == PH_SIGN) begin
      if (in_ch == cbti_pkg::CH_MINUS) begin
        negative_next = !negative;
      end else if (in_ch != cbti_pkg::CH_PLUS) begin
        phase_next = PH_DIGIT;
      end
    end
    if (phase_next == PH_DIGIT) begin
      if (hit) begin
        accum_next = acc_mul + cbti_pkg::VALUE_W'(pos);
      end else begin
        phase_next = PH_STOP;
      end
    end
  end

  always_comb begin
    value_next = '0;
    if (alpha.valid) begin
      value_next = negative_next ? -$signed(accum_next) : $signed(accum_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SPACE;
      negative <= 1'b0;
      accum    <= '0;
      out_vld  <= 1'b0;
    end else begin
      if (advance && in_eos) begin
        phase     <= PH_SPACE;
        negative  <= 1'b0;
        accum     <= '0;
        out_vld   <= 1'b1;
        out_value <= value_next;
        out_ok    <= alpha.valid;
      end else begin
        if (advance) begin
          phase    <= phase_next;
          negative <= negative_next;
          accum    <= accum_next;
        end
        if (result.ready) begin
          out_vld <= 1'b0;
        end
      end
    end
  end

  assign result.valid          = out_vld;
  assign result.value          = out_value;
  assign result.alphabet_valid = out_ok;

`ifndef SYNTH
  a_emit: assert property (@(posedge clk) disable iff (rst)
    advance && in_eos |=> out_vld)
    else $error("end of string did not raise a result");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    advance && in_eos |=> phase == PH_SPACE && !negative && accum == '0)
    else $error("parse state not cleared after end of string");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_ok |-> out_value == '0)
    else $error("nonzero value with invalid alphabet");

  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    advance && !in_eos && phase == PH_STOP |=> phase == PH_STOP)
    else $error("parse left stopped phase within a string");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_vld && !advance |=> in_vld && $stable(in_ch) && $stable(in_eos))
    else $error("held request changed while stalled");
`endif

endmodule

FILE: src/custom_base_text_to_integer_unit.sv
// Text-to-integer converter with a configurable digit alphabet.
// Channel text carries one byte per request (ch, end_of_string); channel
// result carries one signed 32-bit value and an alphabet_valid flag for
// every byte marked end_of_string. Both use valid/ready handshakes.
// The alphabet (up to 16 symbols, base = symbol_count) is set through the
// cfg_we / cfg_index / cfg_wdata write port; write it only while idle.
// Timing: a byte lands in the input register at acceptance and is parsed
// from there; a result is registered as its last byte leaves that register.
// Throughput is one byte per cycle while result is not stalled, set by the
// accumulate (symbol compare, 32x5 multiply, add) on the parse state.
// Reset (rst, synchronous) clears the alphabet registers, the parse state
// and both valid flags; the alphabet reads as invalid until written.
// When result stalls, the pending value holds, and text keeps accepting
// bytes that do not end a string; a byte that ends one waits in the input
// register, with text.ready low, until the result register frees.
module custom_base_text_to_integer_unit #(
  parameter int MaxSymbols = cbti_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cbti_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [cbti_pkg::CFG_W-1:0]     cfg_wdata,
  cbti_in_if.sink                        text,
  cbti_out_if.source                     result
);

  // Alphabet, base and validity, derived from the configuration registers
  cbti_pkg::alpha_t alpha;

  cbti_alpha #(
    .MaxSymbols (MaxSymbols)
  ) u_alpha (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .alpha     (alpha)
  );

  // Input register, parse state machine and result register
  cbti_parse #(
    .MaxSymbols (MaxSymbols)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .alpha  (alpha),
    .text   (text),
    .result (result)
  );

endmodule
